>>> hdl/fixed_point_alu_defines.svh
// Assertion macros for the fixed-point ALU checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FPA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication with a fixed delay in clock cycles, disabled during reset.
`define FPA_ASSERT_LATER(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ## dly (cons)) \
      else $error(msg);

`endif

>>> hdl/fpa_pkg.sv
// Shared types, codes and helpers for the Q24.8 fixed-point ALU.
// No dependencies; the design files and the checker refer to it by scoped names.
`timescale 1ns / 1ps

package fpa_pkg;

   // Operation codes carried in req_type
   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MIN      = 4'd4,
      OP_MAX      = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_FROM_INT = 4'd8,
      OP_TO_INT   = 4'd9
   } fpa_op_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_DIV_ZERO = 2'd2
   } fpa_status_type;

   // How the last stage finishes a request
   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } fpa_kind_type;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } fpa_req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               a_greater;
      logic               a_less;
      logic               a_equal;
      logic [1:0]         status;
   } fpa_rsp_type;

   // Control and data that ride along the divider chain
   typedef struct packed {
      logic               valid;
      fpa_kind_type       kind;
      logic               a_greater;
      logic               a_less;
      logic               a_equal;
      fpa_status_type     status;
      logic signed [31:0] result;     // finished result for simple kinds
      logic signed [63:0] product;    // full product for multiply
      logic               negative;   // quotient sign
      logic [31:0]        divisor;    // divisor magnitude
      logic [31:0]        rem;        // partial remainder
   } fpa_token_type;

   // Saturate a 33-bit signed sum to 32 bits
   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? S32_MIN : S32_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic ovf33(input logic signed [32:0] v);
      return v[32] != v[31];
   endfunction

endpackage

>>> hdl/fpa_prep.sv
// Front cell of the ALU: decodes a request, does the short operations,
// the multiply and the divider setup. Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_prep #(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  fpa_pkg::fpa_req_type    req_data,
   output fpa_pkg::fpa_token_type  next_tok,
   output logic [31+FRAC_BITS:0]   next_nq
);

   localparam int NW = 32 + FRAC_BITS;

   logic signed [31:0]    a;
   logic signed [31:0]    b;
   logic signed [32:0]    sum;
   logic signed [32:0]    diff;
   logic signed [32:0]    incr;
   logic signed [32:0]    decr;
   logic [FRAC_BITS:0]    fi_top;
   logic                  fi_ovf;
   logic signed [31:0]    fi_val;
   logic [31:0]           mag_a;
   logic [31:0]           mag_b;
   fpa_pkg::fpa_token_type tok_in;
   fpa_pkg::fpa_token_type tok_ff;
   logic [NW-1:0]         nq_in;
   logic [NW-1:0]         nq_ff;

   assign a = req_data.operand_a;
   assign b = req_data.operand_b;

   // Wide sums for the add-type operations
   assign sum  = 33'(a) + 33'(b);
   assign diff = 33'(a) - 33'(b);
   assign incr = 33'(a) + 33'sd1;
   assign decr = 33'(a) - 33'sd1;

   // from_int overflows unless the top FRAC_BITS+1 bits are a sign run
   assign fi_top = a[31 -: FRAC_BITS+1];
   assign fi_ovf = !((&fi_top) || !(|fi_top));
   assign fi_val = a << FRAC_BITS;

   assign mag_a = a[31] ? 32'(-a) : a;
   assign mag_b = b[31] ? 32'(-b) : b;

   // Decode and short-operation results
   always_comb begin
      tok_in           = tok_ff;
      tok_in.valid     = accept && !reset;
      tok_in.kind      = fpa_pkg::KIND_SIMPLE;
      tok_in.a_greater = a > b;
      tok_in.a_less    = a < b;
      tok_in.a_equal   = a == b;
      tok_in.status    = fpa_pkg::STATUS_OK;
      tok_in.result    = '0;
      tok_in.product   = 64'(a) * 64'(b);
      tok_in.negative  = a[31] ^ b[31];
      tok_in.divisor   = mag_b;
      tok_in.rem       = '0;
      nq_in            = {mag_a, {FRAC_BITS{1'b0}}};
      case (req_data.req_type)
         fpa_pkg::OP_ADD: begin
            tok_in.result = fpa_pkg::sat33(sum);
            if (fpa_pkg::ovf33(sum)) tok_in.status = fpa_pkg::STATUS_OVERFLOW;
         end
         fpa_pkg::OP_SUB: begin
            tok_in.result = fpa_pkg::sat33(diff);
            if (fpa_pkg::ovf33(diff)) tok_in.status = fpa_pkg::STATUS_OVERFLOW;
         end
         fpa_pkg::OP_MUL: begin
            tok_in.kind = fpa_pkg::KIND_MUL;
         end
         fpa_pkg::OP_DIV: begin
            if (b == '0) begin
               tok_in.status = fpa_pkg::STATUS_DIV_ZERO;
            end else begin
               tok_in.kind = fpa_pkg::KIND_DIV;
            end
         end
         fpa_pkg::OP_MIN: begin
            tok_in.result = (a < b) ? a : b;
         end
         fpa_pkg::OP_MAX: begin
            tok_in.result = (a > b) ? a : b;
         end
         fpa_pkg::OP_INC: begin
            tok_in.result = fpa_pkg::sat33(incr);
            if (fpa_pkg::ovf33(incr)) tok_in.status = fpa_pkg::STATUS_OVERFLOW;
         end
         fpa_pkg::OP_DEC: begin
            tok_in.result = fpa_pkg::sat33(decr);
            if (fpa_pkg::ovf33(decr)) tok_in.status = fpa_pkg::STATUS_OVERFLOW;
         end
         fpa_pkg::OP_FROM_INT: begin
            if (fi_ovf) begin
               tok_in.result = a[31] ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
               tok_in.status = fpa_pkg::STATUS_OVERFLOW;
            end else begin
               tok_in.result = fi_val;
            end
         end
         fpa_pkg::OP_TO_INT: begin
            tok_in.result = a >>> FRAC_BITS;   // floor, never overflows
         end
         default: begin
            tok_in.result = '0;   // unknown opcode
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      nq_ff  <= nq_in;
   end

   assign next_tok = tok_ff;
   assign next_nq  = nq_ff;

endmodule

>>> hdl/fpa_cell.sv
// One cell of the divider chain: a restoring step that yields one quotient bit.
// Numerator bits shift out of the top of nq as quotient bits shift in. Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_cell #(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fpa_pkg::fpa_token_type  prev_tok,
   input  logic [31+FRAC_BITS:0]   prev_nq,
   output fpa_pkg::fpa_token_type  next_tok,
   output logic [31+FRAC_BITS:0]   next_nq
);

   localparam int NW = 32 + FRAC_BITS;

   logic [32:0]            trial;
   logic [32:0]            trial_sub;
   logic                   fits;
   fpa_pkg::fpa_token_type tok_in;
   fpa_pkg::fpa_token_type tok_ff;
   logic [NW-1:0]          nq_in;
   logic [NW-1:0]          nq_ff;

   // Bring down the next numerator bit and try the subtract
   assign trial     = {prev_tok.rem, prev_nq[NW-1]};
   assign trial_sub = trial - {1'b0, prev_tok.divisor};
   assign fits      = trial >= {1'b0, prev_tok.divisor};

   always_comb begin
      tok_in       = prev_tok;
      tok_in.valid = prev_tok.valid && !reset;
      tok_in.rem   = fits ? trial_sub[31:0] : trial[31:0];
      nq_in        = {prev_nq[NW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      nq_ff  <= nq_in;
   end

   assign next_tok = tok_ff;
   assign next_nq  = nq_ff;

endmodule

>>> hdl/fpa_post.sv
// Last stage: rounds and saturates multiply and divide results and
// registers the response. Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_post #(
   parameter int FRAC_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fpa_pkg::fpa_token_type  prev_tok,
   input  logic [31+FRAC_BITS:0]   prev_nq,
   output logic                    rsp_strobe,
   output fpa_pkg::fpa_rsp_type    rsp_data
);

   localparam int NW = 32 + FRAC_BITS;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   logic signed [63:0]   mul_adj;
   logic signed [63:0]   mul_sum;
   logic signed [63:0]   mul_rnd;
   logic                 mul_ovf;
   logic                 round_up;
   logic [NW:0]          qr;
   logic                 ovf_pos;
   logic                 ovf_neg;
   logic                 div_ovf;
   fpa_pkg::fpa_rsp_type rsp_in;
   fpa_pkg::fpa_rsp_type rsp_ff;
   logic                 strobe_in;
   logic                 strobe_ff;

   // Multiply: half away from zero is +half for positive, +half-1 then floor for negative
   assign mul_adj = prev_tok.product[63] ? HALF - 64'sd1 : HALF;
   assign mul_sum = prev_tok.product + mul_adj;
   assign mul_rnd = mul_sum >>> FRAC_BITS;
   assign mul_ovf = !((&mul_rnd[63:31]) || !(|mul_rnd[63:31]));

   // Divide: round up when twice the remainder reaches the divisor
   assign round_up = {prev_tok.rem, 1'b0} >= {1'b0, prev_tok.divisor};
   assign qr       = {1'b0, prev_nq} + {{NW{1'b0}}, round_up};
   assign ovf_pos  = |qr[NW:31];
   assign ovf_neg  = (|qr[NW:32]) || (qr[31] && (|qr[30:0]));
   assign div_ovf  = prev_tok.negative ? ovf_neg : ovf_pos;

   always_comb begin
      strobe_in          = prev_tok.valid;
      rsp_in.a_greater   = prev_tok.a_greater;
      rsp_in.a_less      = prev_tok.a_less;
      rsp_in.a_equal     = prev_tok.a_equal;
      rsp_in.result      = prev_tok.result;
      rsp_in.status      = prev_tok.status;
      case (prev_tok.kind)
         fpa_pkg::KIND_MUL: begin
            if (mul_ovf) begin
               rsp_in.result = mul_rnd[63] ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
               rsp_in.status = fpa_pkg::STATUS_OVERFLOW;
            end else begin
               rsp_in.result = mul_rnd[31:0];
               rsp_in.status = fpa_pkg::STATUS_OK;
            end
         end
         fpa_pkg::KIND_DIV: begin
            if (div_ovf) begin
               rsp_in.result = prev_tok.negative ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
               rsp_in.status = fpa_pkg::STATUS_OVERFLOW;
            end else begin
               rsp_in.result = prev_tok.negative ? -qr[31:0] : qr[31:0];
               rsp_in.status = fpa_pkg::STATUS_OK;
            end
         end
         default: begin
            rsp_in.result = prev_tok.result;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> hdl/fixed_point_alu.sv
// Top level of the signed Q24.8 fixed-point ALU: front cell, divider chain, last stage.
// Depends on fpa_pkg, fpa_prep, fpa_cell and fpa_post.
//
//   channel    ports                          handshake
//   request    start, busy, req_data          taken when start && !busy
//   response   rsp_strobe, rsp_data           one cycle per response, no backpressure
//
// One request per cycle, back to back. A request passes the front cell, the divider chain
// of 32 + FRAC_BITS cells (one quotient bit per cell) and the last stage, each registered;
// every operation travels the same chain so responses leave in request order.
// busy follows reset: no request is taken while reset is high, and reset drops all
// requests in flight. The receiver cannot stall the pipeline.
`timescale 1ns / 1ps

module fixed_point_alu #(
   parameter int FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fpa_pkg::fpa_req_type  req_data,
   output logic                  rsp_strobe,
   output fpa_pkg::fpa_rsp_type  rsp_data
);

   localparam int NW = 32 + FRAC_BITS;

   logic                   accept;
   fpa_pkg::fpa_token_type tok_chain [0:NW];
   logic [NW-1:0]          nq_chain  [0:NW];

   assign busy   = reset;
   assign accept = start && !busy;

   // Decode, short operations, multiply and divider setup
   fpa_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .next_tok (tok_chain[0]),
      .next_nq  (nq_chain[0])
   );

   // Divider chain
   for (genvar i = 0; i < NW; i++) begin : g_cell
      fpa_cell #(
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .prev_tok (tok_chain[i]),
         .prev_nq  (nq_chain[i]),
         .next_tok (tok_chain[i+1]),
         .next_nq  (nq_chain[i+1])
      );
   end

   // Rounding, saturation and response register
   fpa_post #(
      .FRAC_BITS (FRAC_BITS)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .prev_tok   (tok_chain[NW]),
      .prev_nq    (nq_chain[NW]),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> hdl/fpa_checker.sv
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and fixed_point_alu_defines.svh.
`timescale 1ns / 1ps
`include "fixed_point_alu_defines.svh"

module fpa_checker #(
   parameter int FRAC_BITS = 8
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input fpa_pkg::fpa_req_type req_data,
   input logic                 rsp_strobe,
   input fpa_pkg::fpa_rsp_type rsp_data
);

   // Accepting edge to the edge that takes the response
   localparam int LAT = 34 + FRAC_BITS;

   // Every request gets its response after the fixed latency
   `FPA_ASSERT_LATER(a_rsp_follows_req, clock, reset, (start && !busy), LAT, rsp_strobe, "request without response")

   // No response without a request the same distance back
   `FPA_ASSERT_IMPL(a_no_spurious_rsp, clock, reset, rsp_strobe, ($past(start && !busy, LAT)), "response without request")

   // Exactly one of the compare flags is set
   `FPA_ASSERT_IMPL(a_flags_onehot, clock, reset, rsp_strobe, ($onehot({rsp_data.a_greater, rsp_data.a_less, rsp_data.a_equal})), "compare flags not one-hot")

   // The equal flag matches the operands of the matching request
   `FPA_ASSERT_IMPL(a_equal_flag, clock, reset, rsp_strobe, (rsp_data.a_equal == ($past(req_data.operand_a, LAT) == $past(req_data.operand_b, LAT))), "equal flag mismatch")

   // Divide by zero always returns zero
   `FPA_ASSERT_IMPL(a_div_zero_result, clock, reset, (rsp_strobe && (rsp_data.status == fpa_pkg::STATUS_DIV_ZERO)), (rsp_data.result == '0), "divide by zero result not zero")

endmodule

bind fixed_point_alu fpa_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_fpa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
